@@ hw/rtl/txirp_pkg.sv @@
// Shared types and constants for the transaction input record parser.
`default_nettype none

package txirp_pkg;

  // Length of the previous transaction id in bytes.
  localparam int ID_BYTES = 32;
  localparam int ID_IDX_W = (ID_BYTES > 1) ? $clog2(ID_BYTES) : 1;
  // Number of 64-bit id words reported, at most four.
  localparam int ID_WORDS_FULL = (ID_BYTES + 7) / 8;
  localparam int NUM_WORDS = (ID_WORDS_FULL > 4) ? 4 : ID_WORDS_FULL;
  localparam logic [1:0] LAST_WORD = 2'(NUM_WORDS - 1);

  // Result kinds.
  localparam logic [2:0] KIND_VERSION = 3'd0;
  localparam logic [2:0] KIND_COUNT   = 3'd1;
  localparam logic [2:0] KIND_ID      = 3'd2;
  localparam logic [2:0] KIND_VOUT    = 3'd3;
  localparam logic [2:0] KIND_SLEN    = 3'd4;
  localparam logic [2:0] KIND_SEQ     = 3'd5;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_VERSION = 3'd1,
    PH_COUNT   = 3'd2,
    PH_ID      = 3'd3,
    PH_VOUT    = 3'd4,
    PH_SLEN    = 3'd5,
    PH_SKIP    = 3'd6,
    PH_SEQ     = 3'd7
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_tx;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic [7:0]  input_number;
    logic [1:0]  word_number;
    logic        parse_done;
    logic        last_of_run;
  } out_item_t;

  // Field produced by one accepted byte, before id word expansion.
  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [31:0] value;
    logic [7:0]  input_number;
    logic        parse_done;
  } emit_t;

  // Byte write into the id buffer.
  typedef struct packed {
    logic                en;
    logic [ID_IDX_W-1:0] idx;
    logic [7:0]          data;
  } id_wr_t;

  typedef logic [3:0][63:0] id_words_t;

endpackage

`default_nettype wire

@@ hw/rtl/txirp_idbuf.sv @@
// Id byte buffer and assembly of the four display-order id words.
`default_nettype none

module txirp_idbuf
  import txirp_pkg::*;
(
  input  logic      clk,
  input  id_wr_t    wr,
  output id_words_t words
);

  logic [7:0] id_buffer [ID_BYTES];

  // Store one id byte per write.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      id_buffer[wr.idx] <= wr.data;
    end
  end

  // Wire up words: last stored byte is the top byte of word 0, pad with zero.
  for (genvar w = 0; w < 4; w++) begin : g_word
    for (genvar k = 0; k < 8; k++) begin : g_byte
      if (8 * w + k < ID_BYTES) begin : g_fill
        assign words[w][63 - 8 * k -: 8] = id_buffer[ID_BYTES - 1 - (8 * w + k)];
      end else begin : g_pad
        assign words[w][63 - 8 * k -: 8] = 8'h00;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/txirp_parse.sv @@
// Byte-level parse state machine: field accumulation, counters and field emission.
`default_nettype none

module txirp_parse
  import txirp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_item_t in_data,
  output emit_t    emit,
  output id_wr_t   id_wr
);

  phase_t      phase, phase_next;
  logic [5:0]  byte_counter, byte_counter_next;
  logic [31:0] field_accumulator, field_accumulator_next;
  logic [7:0]  inputs_remaining, inputs_remaining_next;
  logic [7:0]  current_input, current_input_next;
  logic [7:0]  skip_remaining, skip_remaining_next;

  // Effective state after a start flag clears the parse.
  phase_t      ph;
  logic [5:0]  bc;
  logic [31:0] acc;
  logic [7:0]  ir;
  logic [7:0]  ci;
  logic [7:0]  sk;
  logic [31:0] acc_le;
  logic        le_full;
  logic        id_last;
  logic [7:0]  sk_dec;

  always_comb begin
    ph  = in_data.start_of_tx ? PH_VERSION : phase;
    bc  = in_data.start_of_tx ? 6'd0 : byte_counter;
    acc = in_data.start_of_tx ? 32'd0 : field_accumulator;
    ir  = in_data.start_of_tx ? 8'd0 : inputs_remaining;
    ci  = in_data.start_of_tx ? 8'd0 : current_input;
    sk  = in_data.start_of_tx ? 8'd0 : skip_remaining;
    acc_le  = acc | ({24'd0, in_data.data_byte} << {bc[1:0], 3'b000});
    le_full = (bc >= 6'd3);
    id_last = ({1'b0, bc} + 7'd1) >= 7'(ID_BYTES);
    sk_dec  = sk - 8'd1;
  end

  // Next phase.
  always_comb begin
    phase_next = ph;
    case (ph)
      PH_VERSION: if (le_full) phase_next = PH_COUNT;
      PH_COUNT:   phase_next = (in_data.data_byte == 8'd0) ? PH_IDLE : PH_ID;
      PH_ID:      if (id_last) phase_next = PH_VOUT;
      PH_VOUT:    if (le_full) phase_next = PH_SLEN;
      PH_SLEN:    phase_next = (in_data.data_byte != 8'd0) ? PH_SKIP : PH_SEQ;
      PH_SKIP:    if (sk_dec == 8'd0) phase_next = PH_SEQ;
      PH_SEQ:     if (le_full) phase_next = (ir <= 8'd1) ? PH_IDLE : PH_ID;
      default:    phase_next = ph;
    endcase
  end

  // Emitted field, id write and datapath next values.
  always_comb begin
    emit = '0;
    emit.input_number = ci;
    id_wr = '0;
    id_wr.idx  = bc[ID_IDX_W-1:0];
    id_wr.data = in_data.data_byte;
    byte_counter_next      = bc;
    field_accumulator_next = acc;
    inputs_remaining_next  = ir;
    current_input_next     = ci;
    skip_remaining_next    = sk;
    case (ph)
      PH_VERSION, PH_VOUT, PH_SEQ: begin
        if (le_full) begin
          emit.valid = 1'b1;
          emit.value = acc_le;
          if (ph == PH_VERSION) begin
            emit.kind = KIND_VERSION;
            emit.input_number = 8'd0;
          end else if (ph == PH_VOUT) begin
            emit.kind = KIND_VOUT;
          end else begin
            emit.kind = KIND_SEQ;
            emit.parse_done = (ir <= 8'd1);
            inputs_remaining_next = ir - 8'd1;
            current_input_next = ci + 8'd1;
          end
          byte_counter_next = 6'd0;
          field_accumulator_next = 32'd0;
        end else begin
          byte_counter_next = bc + 6'd1;
          field_accumulator_next = acc_le;
        end
      end
      PH_COUNT: begin
        emit.valid = 1'b1;
        emit.kind = KIND_COUNT;
        emit.value = {24'd0, in_data.data_byte};
        emit.input_number = 8'd0;
        emit.parse_done = (in_data.data_byte == 8'd0);
        inputs_remaining_next = in_data.data_byte;
        current_input_next = 8'd0;
        byte_counter_next = 6'd0;
      end
      PH_ID: begin
        id_wr.en = ({1'b0, bc} < 7'(ID_BYTES));
        if (id_last) begin
          emit.valid = 1'b1;
          emit.kind = KIND_ID;
          byte_counter_next = 6'd0;
          field_accumulator_next = 32'd0;
        end else begin
          byte_counter_next = bc + 6'd1;
        end
      end
      PH_SLEN: begin
        emit.valid = 1'b1;
        emit.kind = KIND_SLEN;
        emit.value = {24'd0, in_data.data_byte};
        skip_remaining_next = in_data.data_byte;
        byte_counter_next = 6'd0;
        field_accumulator_next = 32'd0;
      end
      PH_SKIP: begin
        skip_remaining_next = sk_dec;
      end
      default: begin
      end
    endcase
    id_wr.en = id_wr.en & accept;
  end

  // Advance state on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      byte_counter      <= 6'd0;
      field_accumulator <= 32'd0;
      inputs_remaining  <= 8'd0;
      current_input     <= 8'd0;
      skip_remaining    <= 8'd0;
    end else if (accept) begin
      phase             <= phase_next;
      byte_counter      <= byte_counter_next;
      field_accumulator <= field_accumulator_next;
      inputs_remaining  <= inputs_remaining_next;
      current_input     <= current_input_next;
      skip_remaining    <= skip_remaining_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/txirp_out.sv @@
// Result register: holds one emitted field and expands id fields into words.
`default_nettype none

module txirp_out
  import txirp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  emit_t     emit,
  input  id_words_t id_words,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [2:0]  kind;
  logic [31:0] base_value;
  logic [7:0]  input_number;
  logic        parse_done;
  logic [1:0]  word_idx;
  logic [1:0]  last_word;
  logic        at_last;
  logic        load;

  assign at_last  = (word_idx == last_word);
  assign in_ready = !out_valid || (out_ready && at_last);
  assign load     = in_valid && in_ready && emit.valid;

  // Control: load a new field, step through id words, drop when drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      word_idx  <= 2'd0;
      last_word <= 2'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      word_idx  <= 2'd0;
      last_word <= (emit.kind == KIND_ID) ? LAST_WORD : 2'd0;
    end else if (out_valid && out_ready) begin
      if (at_last) begin
        out_valid <= 1'b0;
      end else begin
        word_idx <= word_idx + 2'd1;
      end
    end
  end

  // Hold field payload.
  always_ff @(posedge clk) begin
    if (load) begin
      kind         <= emit.kind;
      base_value   <= emit.value;
      input_number <= emit.input_number;
      parse_done   <= emit.parse_done;
    end
  end

  // Present the current transaction.
  always_comb begin
    out_data.kind         = kind;
    out_data.value        = (kind == KIND_ID) ? id_words[word_idx] : {32'd0, base_value};
    out_data.input_number = input_number;
    out_data.word_number  = word_idx;
    out_data.parse_done   = parse_done & at_last;
    out_data.last_of_run  = at_last;
  end

endmodule

`default_nettype wire

@@ hw/rtl/tx_input_record_parser.sv @@
// Top level of the transaction input record parser.
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one raw transaction byte
//   per transaction; start_of_tx marks the first version byte and restarts
//   any parse in progress. Bytes outside a parse are dropped silently.
//   Output channel (out_valid/out_ready/out_data) gives one field per
//   transaction: version, input count, id words, vout, script length and
//   sequence, tagged with the input index.
// Output: a field is registered and appears in the cycle after the byte that completes it.
// Throughput: one byte per cycle while the output accepts. A completed id yields four word
//   transactions from the single result register, so the input stalls while
//   words 0..2 drain; the next byte is taken in the cycle
//   the last word is taken.
// Stall: when out_ready is low the result holds and in_ready drops once the
//   result register is full and not being emptied.
// Reset: rst (synchronous) returns the parser to idle, waiting for a start
//   byte, and empties the result register. The id buffer is not cleared; it
//   is always fully written before it is read.
`default_nettype none

module tx_input_record_parser
  import txirp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  emit_t     emit;
  id_wr_t    id_wr;
  id_words_t id_words;
  logic      accept;

  assign accept = in_valid && in_ready;

  txirp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_data (in_data),
    .emit    (emit),
    .id_wr   (id_wr)
  );

  txirp_idbuf u_idbuf (
    .clk   (clk),
    .wr    (id_wr),
    .words (id_words)
  );

  txirp_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .emit      (emit),
    .id_words  (id_words),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Done only on the final result of a byte.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.parse_done |-> out_data.last_of_run)
    else $error("parse_done without last_of_run");

  // Word index is nonzero only on id words.
  a_word_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.word_number != 2'd0) |-> (out_data.kind == KIND_ID))
    else $error("word_number set on a non-id field");

  // Mid-run words advance by one with the same input.
  a_word_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last_of_run |=>
      out_valid && (out_data.word_number == $past(out_data.word_number) + 2'd1) &&
      (out_data.input_number == $past(out_data.input_number)))
    else $error("id word sequence broken");

  // No byte is taken while an id run still has words after the current one.
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last_of_run |-> !in_ready)
    else $error("input accepted during id word run");

endmodule

`default_nettype wire

@@ test/tx_input_record_parser_tb.sv @@
// Self-checking testbench for the transaction input record parser.
`default_nettype none

module tx_input_record_parser_tb;
  import txirp_pkg::*;

  localparam int ITEMS       = 260;
  localparam int HOLD_CYCLES = 40;
  localparam int MAX_SHOWN   = 10;

  // Field tracker: mirrors the parse and holds the fields still due from the block
  class tx_field_tracker;
    phase_t      phase;
    int unsigned byte_cnt;
    logic [31:0] acc;
    logic [7:0]  id_buf [ID_BYTES];
    logic [7:0]  inputs_left;
    logic [7:0]  input_idx;
    logic [7:0]  skip_left;
    out_item_t   run[$];
    out_item_t   due_fields[$];
    int          mismatches;
    int          parsed_bytes;

    function new();
      phase        = PH_IDLE;
      byte_cnt     = 0;
      acc          = '0;
      inputs_left  = '0;
      input_idx    = '0;
      skip_left    = '0;
      mismatches   = 0;
      parsed_bytes = 0;
      foreach (id_buf[i]) id_buf[i] = '0;
    endfunction

    function void add_field(logic [2:0] kind, logic [63:0] value, logic [7:0] inp,
                            logic [1:0] word, logic done);
      out_item_t f;
      f.kind         = kind;
      f.value        = value;
      f.input_number = inp;
      f.word_number  = word;
      f.parse_done   = done;
      f.last_of_run  = 1'b0;
      run = {run, f};
    endfunction

    // Gather one little-endian byte; true once four bytes are in
    function bit take_le(logic [7:0] b);
      acc      = acc | (32'(b) << (8 * (byte_cnt & 3)));
      byte_cnt = (byte_cnt + 1) & 63;
      return byte_cnt >= 4;
    endfunction

    // Display order: last id byte lands in the top byte of word 0
    function logic [63:0] id_word(int w);
      logic [63:0] v;
      int          d;
      v = '0;
      for (int k = 0; k < 8; k++) begin
        d = 8 * w + k;
        v = {v[55:0], (d < ID_BYTES) ? id_buf[ID_BYTES - 1 - d] : 8'h00};
      end
      return v;
    endfunction

    function void note_byte(in_item_t it);
      logic [7:0] b;
      bit         done;
      out_item_t  f;
      b = it.data_byte;
      if (it.start_of_tx) begin
        phase       = PH_VERSION;
        byte_cnt    = 0;
        acc         = '0;
        inputs_left = '0;
        input_idx   = '0;
        skip_left   = '0;
      end
      if (phase != PH_IDLE) parsed_bytes++;
      run.delete();
      case (phase)
        PH_VERSION: begin
          if (take_le(b)) begin
            add_field(KIND_VERSION, 64'(acc), 8'd0, 2'd0, 1'b0);
            phase    = PH_COUNT;
            byte_cnt = 0;
            acc      = '0;
          end
        end
        PH_COUNT: begin
          inputs_left = b;
          input_idx   = '0;
          add_field(KIND_COUNT, 64'(b), 8'd0, 2'd0, b == 8'd0);
          phase    = (b == 8'd0) ? PH_IDLE : PH_ID;
          byte_cnt = 0;
        end
        PH_ID: begin
          if (byte_cnt < ID_BYTES) id_buf[byte_cnt] = b;
          if (byte_cnt + 1 >= ID_BYTES) begin
            for (int w = 0; w < NUM_WORDS; w++)
              add_field(KIND_ID, id_word(w), input_idx, 2'(w), 1'b0);
            phase    = PH_VOUT;
            byte_cnt = 0;
            acc      = '0;
          end else begin
            byte_cnt = (byte_cnt + 1) & 63;
          end
        end
        PH_VOUT: begin
          if (take_le(b)) begin
            add_field(KIND_VOUT, 64'(acc), input_idx, 2'd0, 1'b0);
            phase    = PH_SLEN;
            byte_cnt = 0;
            acc      = '0;
          end
        end
        PH_SLEN: begin
          add_field(KIND_SLEN, 64'(b), input_idx, 2'd0, 1'b0);
          skip_left = b;
          phase     = (b != 8'd0) ? PH_SKIP : PH_SEQ;
          byte_cnt  = 0;
          acc       = '0;
        end
        PH_SKIP: begin
          skip_left = skip_left - 8'd1;
          if (skip_left == 8'd0) phase = PH_SEQ;
        end
        PH_SEQ: begin
          if (take_le(b)) begin
            done = inputs_left <= 8'd1;
            add_field(KIND_SEQ, 64'(acc), input_idx, 2'd0, done);
            inputs_left = inputs_left - 8'd1;
            input_idx   = input_idx + 8'd1;
            phase       = done ? PH_IDLE : PH_ID;
            byte_cnt    = 0;
            acc         = '0;
          end
        end
        default: ;
      endcase
      // Mark the final field of this byte and queue the run
      foreach (run[i]) begin
        f             = run[i];
        f.last_of_run = (i == run.size() - 1);
        due_fields    = {due_fields, f};
      end
    endfunction

    function void report(string why, out_item_t want, out_item_t got);
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display({"tb: %s: expected kind=%0d value=%h in=%0d word=%0d done=%b last=%b,",
                  " got kind=%0d value=%h in=%0d word=%0d done=%b last=%b"},
                 why, want.kind, want.value, want.input_number, want.word_number,
                 want.parse_done, want.last_of_run, got.kind, got.value,
                 got.input_number, got.word_number, got.parse_done, got.last_of_run);
    endfunction

    function void check_field(out_item_t got);
      out_item_t want;
      if (due_fields.size() == 0) begin
        report("field with nothing due", '0, got);
      end else begin
        want = due_fields.pop_front();
        if (got.kind !== want.kind || got.value !== want.value ||
            got.input_number !== want.input_number || got.word_number !== want.word_number ||
            got.parse_done !== want.parse_done || got.last_of_run !== want.last_of_run)
          report("field mismatch", want, got);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  tx_field_tracker fields;
  in_item_t        tx_bytes[$];
  int              send_idle_pct = 6;
  int              recv_idle_pct = 78;
  bit              hold_req = 1'b0;

  tx_input_record_parser dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Bound the run
  initial begin
    #(12 * 300000);
    $display("tb: failure");
    $finish;
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic void push_byte(logic [7:0] d, logic s);
    in_item_t it;
    it.data_byte   = d;
    it.start_of_tx = s;
    tx_bytes = {tx_bytes, it};
  endfunction

  function automatic void push_le32(logic [31:0] v, logic s);
    push_byte(v[7:0], s);
    push_byte(v[15:8], 1'b0);
    push_byte(v[23:16], 1'b0);
    push_byte(v[31:24], 1'b0);
  endfunction

  // Build one well-formed transaction with random content
  function automatic void queue_tx(int n_in, bit zero_slen);
    int slen;
    push_le32(rand_word(), 1'b1);
    push_byte(8'(n_in), 1'b0);
    for (int i = 0; i < n_in; i++) begin
      for (int k = 0; k < ID_BYTES; k++) push_byte(rand_byte(), 1'b0);
      push_le32(rand_word(), 1'b0);
      slen = (zero_slen || $urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
      push_byte(8'(slen), 1'b0);
      for (int k = 0; k < slen; k++) push_byte(rand_byte(), 1'b0);
      push_le32(rand_word(), 1'b0);
    end
  endfunction

  // Offer one byte, idling first at random; hold valid until accepted
  task automatic send_byte(in_item_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    fields.note_byte(b);
  endtask

  task automatic send_queued();
    while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front());
  endtask

  // Check every accepted result transaction
  always @(posedge clk) begin
    if (rst === 1'b0 && out_valid && out_ready) fields.check_field(out_data);
  end

  // Drive out_ready; hold off for a long stretch on request
  initial begin
    out_ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      @(posedge clk);
    end
  end

  // Reset, directed bytes, random transactions, drain
  initial begin
    int  r;
    int  n_in;
    int  keep;
    bit  quiet;
    bit  first_tx;
    quiet    = 1'b0;
    first_tx = 1'b1;
    fields   = new();
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Bytes before any start are dropped
    push_byte(8'hff, 1'b0);
    push_byte(8'h00, 1'b0);
    // All-ones version with a zero input count
    push_le32(32'hffff_ffff, 1'b1);
    push_byte(8'h00, 1'b0);
    // Zero version, full count, abandoned inside the id
    push_le32(32'h0000_0000, 1'b1);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h5a, 1'b0);
    // Restart inside the version, then restart again
    push_byte(8'h78, 1'b1);
    push_byte(8'h56, 1'b0);
    push_le32(32'h1234_5678, 1'b1);
    push_byte(8'h00, 1'b0);
    // Trailing byte after the parse is done
    push_byte(8'ha5, 1'b0);
    send_queued();

    // Random transactions, mostly well formed
    while (fields.parsed_bytes < ITEMS) begin
      if (fields.parsed_bytes >= 2 * ITEMS / 3) begin
        if (!quiet) begin
          quiet         = 1'b1;
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req      = 1'b1;
        end
      end else if (fields.parsed_bytes >= ITEMS / 3) begin
        send_idle_pct = 78;
        recv_idle_pct = 6;
      end
      r = $urandom_range(99);
      if (r < 8) begin
        // Drop stray bytes
        repeat ($urandom_range(1, 3)) push_byte(rand_byte(), 1'b0);
      end else begin
        case ($urandom_range(9))
          0:       n_in = 0;
          7, 8:    n_in = 2;
          9:       n_in = 3;
          default: n_in = 1;
        endcase
        if (first_tx) n_in = 1;
        queue_tx(n_in, first_tx);
        first_tx = 1'b0;
        if (r < 24) begin
          // Cut the transaction short; the next start abandons it
          keep = $urandom_range(1, tx_bytes.size() - 1);
          while (tx_bytes.size() > keep) void'(tx_bytes.pop_back());
        end else if (r < 40) begin
          repeat ($urandom_range(1, 3)) push_byte(rand_byte(), 1'b0);
        end
      end
      send_queued();
    end
    in_valid <= 1'b0;

    // Drain outstanding fields, then allow for late extras
    while (fields.due_fields.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fields.mismatches == 0 && fields.due_fields.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
